>>> rtl/hrsp_pkg.sv
// Package for the HTTP request stream parser: segment and status codes,
// parse phases, and the item passed from the front to the back.
// No dependencies.
package hrsp_pkg;

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_PATH    = 3'd1,
        PH_VERSION = 3'd2,
        PH_HEADERS = 3'd3,
        PH_BODY    = 3'd4,
        PH_DISCARD = 3'd5
    } phase_t;

    localparam logic [2:0] SEG_METHOD  = 3'd0;
    localparam logic [2:0] SEG_PATH    = 3'd1;
    localparam logic [2:0] SEG_VERSION = 3'd2;
    localparam logic [2:0] SEG_HEADER  = 3'd3;
    localparam logic [2:0] SEG_TYPE    = 3'd4;
    localparam logic [2:0] SEG_BODY    = 3'd5;
    localparam logic [2:0] SEG_DROP    = 3'd6;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_LINE   = 3'd1;
    localparam logic [2:0] ST_LINE_LONG = 3'd2;
    localparam logic [2:0] ST_MALFORMED = 3'd3;
    localparam logic [2:0] ST_METHOD    = 3'd4;
    localparam logic [2:0] ST_PATH      = 3'd5;
    localparam logic [2:0] ST_VERSION   = 3'd6;

    localparam logic [1:0] HM_NAME   = 2'd0;
    localparam logic [1:0] HM_LENGTH = 2'd1;
    localparam logic [1:0] HM_TYPE   = 2'd2;
    localparam logic [1:0] HM_SKIP   = 2'd3;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3b;

    localparam int LEN_NAME_LEN  = 15;
    localparam int TYPE_NAME_LEN = 13;
    localparam logic [15:0] CNT_CAP = 16'hffff;

    // lower-case header name characters
    function automatic logic [7:0] len_name_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:  c = "c";
            4'd1:  c = "o";
            4'd2:  c = "n";
            4'd3:  c = "t";
            4'd4:  c = "e";
            4'd5:  c = "n";
            4'd6:  c = "t";
            4'd7:  c = "-";
            4'd8:  c = "l";
            4'd9:  c = "e";
            4'd10: c = "n";
            4'd11: c = "g";
            4'd12: c = "t";
            4'd13: c = "h";
            4'd14: c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] type_name_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:  c = "c";
            4'd1:  c = "o";
            4'd2:  c = "n";
            4'd3:  c = "t";
            4'd4:  c = "e";
            4'd5:  c = "n";
            4'd6:  c = "t";
            4'd7:  c = "-";
            4'd8:  c = "t";
            4'd9:  c = "y";
            4'd10: c = "p";
            4'd11: c = "e";
            4'd12: c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // one classified byte passed from the front to the back
    typedef struct packed {
        logic [7:0]  out_byte;
        logic [2:0]  segment;
        logic [2:0]  status;
        logic [31:0] parsed_length;
        logic [11:0] body_bytes;
        logic        final_res;
    } res_t;

    localparam int RES_W = $bits(res_t);

endpackage

>>> rtl/hrsp_front.sv
// Front of the parser: accepts request bytes, runs the parse state and
// emits up to two classified results per byte. Depends on hrsp_pkg.
module hrsp_front
    import hrsp_pkg::*;
#(
    parameter int REQUEST_LINE_MAX  = 256,
    parameter int METHOD_MAX        = 16,
    parameter int PATH_FIELD_MAX    = 256,
    parameter int VERSION_FIELD_MAX = 16,
    parameter int CONTENT_TYPE_MAX  = 64,
    parameter int BODY_MAX          = 4096
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic [1:0] res_cnt,
    output res_t       res0,
    output res_t       res1
);

    localparam logic [15:0] LINE_LIM = 16'(REQUEST_LINE_MAX);
    localparam logic [15:0] METH_LIM = 16'(METHOD_MAX);
    localparam logic [15:0] PATH_LIM = 16'(PATH_FIELD_MAX);
    localparam logic [15:0] VER_LIM  = 16'(VERSION_FIELD_MAX);
    localparam logic [15:0] TYPE_LIM = 16'(CONTENT_TYPE_MAX - 1);
    localparam logic [31:0] BODY_LIM = 32'(BODY_MAX - 1);

    phase_t      phase_reg, phase_next;
    logic        cr_reg, cr_next;
    logic [15:0] line_reg, line_next;
    logic [15:0] field_reg, field_next;
    logic [3:0]  pos_reg, pos_next;
    logic [1:0]  flags_reg, flags_next;
    logic [1:0]  hmode_reg, hmode_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] pend_reg, pend_next;
    logic        hit_reg, hit_next;
    logic        digit_reg, digit_next;
    logic [31:0] body_reg, body_next;
    logic [15:0] type_reg, type_next;
    logic [2:0]  err_reg, err_next;
    logic        empty_reg, empty_next;

    // hold parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_METHOD;
            cr_reg    <= 1'b0;
            line_reg  <= '0;
            field_reg <= '0;
            pos_reg   <= '0;
            flags_reg <= 2'b11;
            hmode_reg <= HM_NAME;
            len_reg   <= '0;
            pend_reg  <= '0;
            hit_reg   <= 1'b0;
            digit_reg <= 1'b0;
            body_reg  <= '0;
            type_reg  <= '0;
            err_reg   <= ST_OK;
            empty_reg <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            cr_reg    <= cr_next;
            line_reg  <= line_next;
            field_reg <= field_next;
            pos_reg   <= pos_next;
            flags_reg <= flags_next;
            hmode_reg <= hmode_next;
            len_reg   <= len_next;
            pend_reg  <= pend_next;
            hit_reg   <= hit_next;
            digit_reg <= digit_next;
            body_reg  <= body_next;
            type_reg  <= type_next;
            err_reg   <= err_next;
            empty_reg <= empty_next;
        end
    end

    // classify bytes; at most two passes through the byte step per cycle
    always_comb
    begin
        logic [7:0]  b;
        logic [7:0]  lc;
        logic [2:0]  seg;
        logic [1:0]  n;
        logic        done;
        logic [4:0]  p;
        logic [3:0]  dg;
        logic [31:0] lim;
        res_t        r [2];
        phase_next = phase_reg;
        cr_next    = cr_reg;
        line_next  = line_reg;
        field_next = field_reg;
        pos_next   = pos_reg;
        flags_next = flags_reg;
        hmode_next = hmode_reg;
        len_next   = len_reg;
        pend_next  = pend_reg;
        hit_next   = hit_reg;
        digit_next = digit_reg;
        body_next  = body_reg;
        type_next  = type_reg;
        err_next   = err_reg;
        empty_next = empty_reg;
        n    = 2'd0;
        done = 1'b0;
        r[0] = '0;
        r[1] = '0;
        b    = 8'h00;
        seg  = SEG_DROP;
        lc   = 8'h00;
        p    = '0;
        dg   = '0;
        lim  = '0;

        if (phase_next <= PH_HEADERS && cr_reg)
        begin
            cr_next = 1'b0;
            if (data_byte == CH_LF)
            begin
                r[0] = '{CH_CR, SEG_DROP, err_next, len_next, body_next[11:0], 1'b0};
                r[1] = '{CH_LF, SEG_DROP, err_next, len_next, body_next[11:0], 1'b0};
                n = 2'd2;
                done = 1'b1;
                // close the line
                if (phase_next <= PH_VERSION)
                begin
                    if (line_next >= LINE_LIM)
                        err_next = ST_LINE_LONG;
                    else if (err_next == ST_OK)
                    begin
                        if (phase_next != PH_VERSION)
                            err_next = ST_MALFORMED;
                        else if (field_next >= VER_LIM)
                            err_next = ST_VERSION;
                    end
                    phase_next = (err_next != ST_OK) ? PH_DISCARD : PH_HEADERS;
                    empty_next = 1'b1; pos_next = '0; flags_next = 2'b11;
                    hmode_next = HM_NAME; pend_next = '0; hit_next = 1'b0;
                    digit_next = 1'b0; type_next = '0;
                end
                else if (phase_next == PH_HEADERS)
                begin
                    if (empty_next)
                        phase_next = PH_BODY;
                    else
                    begin
                        if (hit_next)
                            len_next = pend_next;
                        empty_next = 1'b1; pos_next = '0; flags_next = 2'b11;
                        hmode_next = HM_NAME; pend_next = '0; hit_next = 1'b0;
                        digit_next = 1'b0; type_next = '0;
                    end
                end
            end
        end

        // up to two byte steps: the held CR, then the current byte
        for (int k = 0; k < 2; k++)
        begin
            logic act;
            act = 1'b0;
            if (k == 0)
            begin
                act = cr_reg && !done && phase_reg <= PH_HEADERS;
                b = CH_CR;
            end
            else
            begin
                b = data_byte;
                act = !done;
                if (phase_next <= PH_HEADERS && data_byte == CH_CR && !last_byte && act)
                begin
                    cr_next = 1'b1;
                    act = 1'b0;
                end
            end
            if (act)
            begin
                seg = SEG_DROP;
                unique case (phase_next)
                    PH_METHOD, PH_PATH:
                    begin
                        if (line_next < CNT_CAP) line_next = line_next + 16'd1;
                        if (b == CH_SPACE)
                        begin
                            if (err_next == ST_OK &&
                                field_next >= ((phase_next == PH_METHOD) ? METH_LIM : PATH_LIM))
                                err_next = (phase_next == PH_METHOD) ? ST_METHOD : ST_PATH;
                            phase_next = (phase_next == PH_METHOD) ? PH_PATH : PH_VERSION;
                            field_next = '0;
                            seg = SEG_DROP;
                        end
                        else
                        begin
                            if (field_next < CNT_CAP) field_next = field_next + 16'd1;
                            seg = (phase_next == PH_METHOD) ? SEG_METHOD : SEG_PATH;
                        end
                    end
                    PH_VERSION:
                    begin
                        if (line_next < CNT_CAP) line_next = line_next + 16'd1;
                        if (field_next < CNT_CAP) field_next = field_next + 16'd1;
                        seg = SEG_VERSION;
                    end
                    PH_HEADERS:
                    begin
                        seg = SEG_HEADER;
                        empty_next = 1'b0;
                        case (hmode_next)
                            HM_NAME:
                            begin
                                lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
                                if (flags_next[0] && !(5'(pos_next) < 5'(LEN_NAME_LEN)
                                        && lc == len_name_char(pos_next)))
                                    flags_next[0] = 1'b0;
                                if (flags_next[1] && !(5'(pos_next) < 5'(TYPE_NAME_LEN)
                                        && lc == type_name_char(pos_next)))
                                    flags_next[1] = 1'b0;
                                p = 5'(pos_next) + 5'd1;
                                pos_next = p[3:0];
                                if (flags_next[0] && p == 5'(LEN_NAME_LEN))
                                begin
                                    hmode_next = HM_LENGTH; hit_next = 1'b1;
                                    pend_next = '0; digit_next = 1'b0;
                                end
                                else if (flags_next[1] && p == 5'(TYPE_NAME_LEN))
                                begin
                                    hmode_next = HM_TYPE; type_next = '0;
                                end
                                else if (flags_next == 2'b00)
                                    hmode_next = HM_SKIP;
                            end
                            HM_LENGTH:
                            begin
                                if (b == CH_SPACE && !digit_next)
                                begin
                                end
                                else if (b >= "0" && b <= "9")
                                begin
                                    dg = 4'(b - "0");
                                    if (pend_next > 32'd429496729 ||
                                        (pend_next == 32'd429496729 && dg > 4'd5))
                                        pend_next = 32'hffffffff;
                                    else
                                        pend_next = (pend_next << 3) + (pend_next << 1)
                                                    + 32'(dg);
                                    digit_next = 1'b1;
                                end
                                else
                                    hmode_next = HM_SKIP;
                            end
                            HM_TYPE:
                            begin
                                if (type_next == '0 && b == CH_SPACE)
                                begin
                                end
                                else if (b == CH_SEMI || b == CH_LF || b == CH_CR)
                                    hmode_next = HM_SKIP;
                                else if (type_next < TYPE_LIM)
                                begin
                                    type_next = type_next + 16'd1;
                                    seg = SEG_TYPE;
                                end
                                else
                                    hmode_next = HM_SKIP;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    PH_BODY:
                    begin
                        lim = BODY_LIM;
                        if (len_next > '0 && len_next < BODY_LIM)
                            lim = len_next;
                        if (body_next < lim)
                        begin
                            body_next = body_next + 32'd1;
                            seg = SEG_BODY;
                        end
                    end
                    default:
                        seg = SEG_DROP;
                endcase
                r[n[0]] = '{b, seg, err_next, len_next, body_next[11:0], 1'b0};
                n = n + 2'd1;
            end
        end

        // finish the request on its last byte
        if (last_byte)
        begin
            if (n == 2'd0)
            begin
                r[0] = '{8'h00, SEG_DROP, err_next, len_next, body_next[11:0], 1'b0};
                n = 2'd1;
            end
            r[n[1] ? 1 : 0].status = (phase_next <= PH_VERSION) ? ST_NO_LINE : err_next;
            r[n[1] ? 1 : 0].parsed_length = len_next;
            r[n[1] ? 1 : 0].body_bytes = body_next[11:0];
            r[n[1] ? 1 : 0].final_res = 1'b1;
            phase_next = PH_METHOD; cr_next = 1'b0; line_next = '0; field_next = '0;
            pos_next = '0; flags_next = 2'b11; hmode_next = HM_NAME; len_next = '0;
            pend_next = '0; hit_next = 1'b0; digit_next = 1'b0; body_next = '0;
            type_next = '0; err_next = ST_OK; empty_next = 1'b0;
        end
        res_cnt = n;
        res0 = r[0];
        res1 = r[1];
    end

endmodule

>>> rtl/hrsp_queue.sv
// Result queue between the front and the back; takes up to two results
// per cycle and gives one per cycle while read. Depends on hrsp_pkg.
module hrsp_queue
    import hrsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] wr_cnt,
    input  res_t       wr0,
    input  res_t       wr1,
    input  logic       rd,
    output logic       has_room,
    output logic       not_empty,
    output res_t       rd_data
);

    localparam int DEPTH = 8;

    res_t        mem_reg [DEPTH];
    logic [2:0]  wp_reg, rp_reg;
    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_next;

    assign not_empty = (cnt_reg != 4'd0);
    assign has_room  = (cnt_reg <= 4'(DEPTH - 2));
    assign rd_data   = mem_reg[rp_reg];
    assign cnt_next  = cnt_reg + 4'(wr_cnt) - 4'(rd && not_empty);

    // store writes
    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
            mem_reg[wp_reg] <= wr0;
        if (wr_cnt == 2'd2)
            mem_reg[wp_reg + 3'd1] <= wr1;
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + 3'(wr_cnt);
            if (rd && not_empty)
                rp_reg <= rp_reg + 3'd1;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> rtl/http_request_stream_parser_top.sv
// Usage
// Input channel: push/full with data_byte and last_byte. A transaction
// happens at a clock edge with push high and full low.
// Result channel: empty/pop. While empty is low the oldest result sits on
// out_byte, segment, status, parsed_length, body_bytes and final_res;
// pop with empty low takes it.
// Throughput: one byte per cycle while full is low. A byte gives zero, one or two results;
// the result port delivers one result per cycle while pop is high, so a CR LF pair drains
// at one result a cycle through the eight-entry queue.
// A result is written into the queue at the clock edge that takes its byte.
// Reset clears the parse state and the queue. A stalled receiver fills the
// queue; full rises when fewer than two free entries remain, and no
// result is dropped.
// Top level of the parser; depends on hrsp_pkg, hrsp_front, hrsp_queue.
module http_request_stream_parser_top
    import hrsp_pkg::*;
#(
    parameter int REQUEST_LINE_MAX  = 256,
    parameter int METHOD_MAX        = 16,
    parameter int PATH_FIELD_MAX    = 256,
    parameter int VERSION_FIELD_MAX = 16,
    parameter int CONTENT_TYPE_MAX  = 64,
    parameter int BODY_MAX          = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic [2:0]  segment,
    output logic [2:0]  status,
    output logic [31:0] parsed_length,
    output logic [11:0] body_bytes,
    output logic        final_res
);

    logic       take, room, avail;
    logic [1:0] cnt;
    res_t       r0, r1, head;

    assign full = !room;
    assign take = push && room;

    hrsp_front #(
        .REQUEST_LINE_MAX (REQUEST_LINE_MAX),
        .METHOD_MAX       (METHOD_MAX),
        .PATH_FIELD_MAX   (PATH_FIELD_MAX),
        .VERSION_FIELD_MAX(VERSION_FIELD_MAX),
        .CONTENT_TYPE_MAX (CONTENT_TYPE_MAX),
        .BODY_MAX         (BODY_MAX)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .data_byte(data_byte),
        .last_byte(last_byte),
        .res_cnt  (cnt),
        .res0     (r0),
        .res1     (r1)
    );

    hrsp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_cnt   (take ? cnt : 2'd0),
        .wr0      (r0),
        .wr1      (r1),
        .rd       (pop),
        .has_room (room),
        .not_empty(avail),
        .rd_data  (head)
    );

    assign empty          = !avail;
    assign out_byte       = head.out_byte;
    assign segment        = head.segment;
    assign status         = head.status;
    assign parsed_length  = head.parsed_length;
    assign body_bytes     = head.body_bytes;
    assign final_res      = head.final_res;

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for http_request_stream_parser_top: drives HTTP
// requests byte by byte and checks every classified byte against a predictor.
// Depends on hrsp_pkg and the parser RTL.
module tb;
    import hrsp_pkg::*;

    localparam int REQ_LINE_MAX = 256;
    localparam int METHOD_LIM   = 16;
    localparam int PATH_LIM     = 256;
    localparam int VERSION_LIM  = 16;
    localparam int CTYPE_LIM    = 64;
    localparam int BODY_LIM     = 4096;
    localparam int CYCLE_LIMIT  = 1000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  out_byte;
    logic [2:0]  segment;
    logic [2:0]  status;
    logic [31:0] parsed_length;
    logic [11:0] body_bytes;
    logic        final_res;

    http_request_stream_parser_top dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .data_byte(data_byte), .last_byte(last_byte), .empty(empty), .pop(pop),
        .out_byte(out_byte), .segment(segment), .status(status),
        .parsed_length(parsed_length), .body_bytes(body_bytes),
        .final_res(final_res)
    );

    // free-running clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // parser state mirrored by the predictor
    phase_t      ps;
    bit          cr_held;
    int          line_cnt, fld_cnt, tcnt, bcnt;
    int          nm_pos;
    logic [1:0]  nm_live, hmode;
    logic [31:0] clen, plen;
    logic [2:0]  err;
    bit          blank, plen_hit, plen_digit;

    string len_str = "content-length:";
    string ctype_str = "content-type:";

    res_t step_res[$];
    res_t expected_q[$];
    logic [8:0] req_q[$];

    int n_items, n_results, n_finals, n_mismatch, cycles;
    int snd_idle, rcv_idle, rcv_hold;

    typedef struct {
        logic [7:0] b;
        logic       l;
        bit         typed;
        res_t       r;
    } dir_row_t;

    // directed rows: early end at reset, a minimal request, a malformed line
    dir_row_t dir_tab[17] = '{
        '{8'h00, 1'b1, 1'b1, '{8'h00, SEG_METHOD, ST_NO_LINE, 32'd0, 12'd0, 1'b1}},
        '{8'hff, 1'b1, 1'b1, '{8'hff, SEG_METHOD, ST_NO_LINE, 32'd0, 12'd0, 1'b1}},
        '{CH_CR, 1'b1, 1'b1, '{CH_CR, SEG_METHOD, ST_NO_LINE, 32'd0, 12'd0, 1'b1}},
        '{"G", 1'b0, 1'b0, '0},
        '{CH_SPACE, 1'b0, 1'b0, '0},
        '{"/", 1'b0, 1'b0, '0},
        '{CH_SPACE, 1'b0, 1'b0, '0},
        '{"H", 1'b0, 1'b0, '0},
        '{CH_CR, 1'b0, 1'b0, '0},
        '{CH_LF, 1'b0, 1'b0, '0},
        '{CH_CR, 1'b0, 1'b0, '0},
        '{CH_LF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'hff, 1'b1, 1'b0, '0},
        '{"x", 1'b0, 1'b0, '0},
        '{CH_CR, 1'b0, 1'b0, '0},
        '{CH_LF, 1'b1, 1'b1, '{CH_LF, SEG_DROP, ST_MALFORMED, 32'd0, 12'd0, 1'b1}}
    };

    function automatic void start_hdr();
        blank = 1'b1;
        nm_pos = 0;
        nm_live = 2'b11;
        hmode = HM_NAME;
        plen = '0;
        plen_hit = 1'b0;
        plen_digit = 1'b0;
        tcnt = 0;
    endfunction

    function automatic void clear_parse();
        ps = PH_METHOD;
        cr_held = 1'b0;
        line_cnt = 0;
        fld_cnt = 0;
        clen = '0;
        bcnt = 0;
        err = ST_OK;
        start_hdr();
        blank = 1'b0;
    endfunction

    function automatic void note(input logic [7:0] b, input logic [2:0] seg);
        res_t r;
        r.out_byte = b;
        r.segment = seg;
        r.status = err;
        r.parsed_length = clen;
        r.body_bytes = bcnt[11:0];
        r.final_res = 1'b0;
        step_res.push_back(r);
    endfunction

    // close a line on CR LF: judge the request line or commit a header
    function automatic void close_line();
        if (ps <= PH_VERSION)
        begin
            if (line_cnt >= REQ_LINE_MAX)
                err = ST_LINE_LONG;
            else if (err == ST_OK)
            begin
                if (ps != PH_VERSION)
                    err = ST_MALFORMED;
                else if (fld_cnt >= VERSION_LIM)
                    err = ST_VERSION;
            end
            ps = (err != ST_OK) ? PH_DISCARD : PH_HEADERS;
            start_hdr();
        end
        else if (ps == PH_HEADERS)
        begin
            if (blank)
                ps = PH_BODY;
            else
            begin
                if (plen_hit)
                    clen = plen;
                start_hdr();
            end
        end
    endfunction

    // match header names and pick out the length and type values
    function automatic logic [2:0] hdr_seg(input logic [7:0] b);
        logic [2:0] seg;
        logic [7:0] lc;
        logic [1:0] fl;
        int p;
        seg = SEG_HEADER;
        blank = 1'b0;
        if (hmode == HM_NAME)
        begin
            lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
            p = nm_pos;
            fl = nm_live;
            if (fl[0] && !(p < LEN_NAME_LEN && lc == len_str[p]))
                fl[0] = 1'b0;
            if (fl[1] && !(p < TYPE_NAME_LEN && lc == ctype_str[p]))
                fl[1] = 1'b0;
            p++;
            nm_pos = p % 16;
            nm_live = fl;
            if (fl[0] && p == LEN_NAME_LEN)
            begin
                hmode = HM_LENGTH;
                plen_hit = 1'b1;
                plen = '0;
                plen_digit = 1'b0;
            end
            else if (fl[1] && p == TYPE_NAME_LEN)
            begin
                hmode = HM_TYPE;
                tcnt = 0;
            end
            else if (fl == 2'b00)
                hmode = HM_SKIP;
        end
        else if (hmode == HM_LENGTH)
        begin
            if (b == CH_SPACE && !plen_digit)
                hmode = HM_LENGTH;
            else if (b >= "0" && b <= "9")
            begin
                if (plen > 32'd429496729 || (plen == 32'd429496729 && b > "5"))
                    plen = 32'hffffffff;
                else
                    plen = plen * 10 + (b - "0");
                plen_digit = 1'b1;
            end
            else
                hmode = HM_SKIP;
        end
        else if (hmode == HM_TYPE)
        begin
            if (tcnt == 0 && b == CH_SPACE)
                hmode = HM_TYPE;
            else if (b == CH_SEMI || b == CH_LF || b == CH_CR)
                hmode = HM_SKIP;
            else if (tcnt < CTYPE_LIM - 1)
            begin
                tcnt++;
                seg = SEG_TYPE;
            end
            else
                hmode = HM_SKIP;
        end
        return seg;
    endfunction

    function automatic void classify(input logic [7:0] b);
        int lim;
        case (ps)
            PH_METHOD, PH_PATH:
            begin
                if (line_cnt < CNT_CAP) line_cnt++;
                if (b == CH_SPACE)
                begin
                    lim = (ps == PH_METHOD) ? METHOD_LIM : PATH_LIM;
                    if (fld_cnt >= lim && err == ST_OK)
                        err = (ps == PH_METHOD) ? ST_METHOD : ST_PATH;
                    ps = (ps == PH_METHOD) ? PH_PATH : PH_VERSION;
                    fld_cnt = 0;
                    note(b, SEG_DROP);
                end
                else
                begin
                    if (fld_cnt < CNT_CAP) fld_cnt++;
                    note(b, (ps == PH_METHOD) ? SEG_METHOD : SEG_PATH);
                end
            end
            PH_VERSION:
            begin
                if (line_cnt < CNT_CAP) line_cnt++;
                if (fld_cnt < CNT_CAP) fld_cnt++;
                note(b, SEG_VERSION);
            end
            PH_HEADERS: note(b, hdr_seg(b));
            PH_BODY:
            begin
                lim = BODY_LIM - 1;
                if (clen > 0 && clen < lim)
                    lim = clen;
                if (bcnt < lim)
                begin
                    bcnt++;
                    note(b, SEG_BODY);
                end
                else
                    note(b, SEG_DROP);
            end
            default: note(b, SEG_DROP);
        endcase
    endfunction

    // work out the results of one accepted byte and queue them
    function automatic void predict_byte(input logic [7:0] b, input logic l);
        bit done;
        done = 1'b0;
        step_res.delete();
        if (ps <= PH_HEADERS)
        begin
            if (cr_held)
            begin
                cr_held = 1'b0;
                if (b == CH_LF)
                begin
                    note(CH_CR, SEG_DROP);
                    note(CH_LF, SEG_DROP);
                    close_line();
                    done = 1'b1;
                end
                else
                    classify(CH_CR);
            end
            if (!done)
            begin
                if (b == CH_CR && !l)
                    cr_held = 1'b1;
                else
                    classify(b);
            end
        end
        else
            classify(b);
        if (l)
        begin
            if (step_res.size() == 0)
                note(8'h00, SEG_DROP);
            step_res[$].status = (ps <= PH_VERSION) ? ST_NO_LINE : err;
            step_res[$].parsed_length = clen;
            step_res[$].body_bytes = bcnt[11:0];
            step_res[$].final_res = 1'b1;
            clear_parse();
        end
        foreach (step_res[i])
            expected_q.push_back(step_res[i]);
    endfunction

    // offer one byte, idling at random, and predict once it is taken
    task automatic send(input logic [7:0] b, input logic l);
        while ($urandom_range(99) < snd_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        data_byte <= b;
        last_byte <= l;
        do @(posedge clk); while (full);
        predict_byte(b, l);
        n_items++;
    endtask

    function automatic void add_str(input string s, input bit mix);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (mix && c >= "a" && c <= "z" && $urandom_range(1))
                c = c - 8'd32;
            req_q.push_back({1'b0, c});
        end
    endfunction

    function automatic void add_rand(input int n, input logic [7:0] lo, input logic [7:0] hi);
        for (int i = 0; i < n; i++)
            req_q.push_back({1'b0, 8'($urandom_range(hi, lo))});
    endfunction

    function automatic void add_crlf();
        req_q.push_back({1'b0, CH_CR});
        req_q.push_back({1'b0, CH_LF});
    endfunction

    // build one request: mostly well formed, some truncated, some noise
    function automatic void build_request(input bit huge_body);
        int kind, n;
        req_q.delete();
        kind = huge_body ? 99 : $urandom_range(99);
        if (kind < 8)
            add_rand($urandom_range(12, 1), 8'h00, 8'hff);
        else
        begin
            n = ($urandom_range(19) == 0) ? $urandom_range(18, 14) : $urandom_range(6, 1);
            add_rand(n, "A", "Z");
            if ($urandom_range(24) != 0) add_str(" ", 0);
            add_str("/", 0);
            n = ($urandom_range(29) == 0) ? $urandom_range(262, 240) : $urandom_range(10);
            add_rand(n, "a", "z");
            if ($urandom_range(24) != 0) add_str(" ", 0);
            if ($urandom_range(19) == 0)
                add_rand($urandom_range(20, 10), " ", "~");
            else
                add_str("HTTP/1.1", 0);
            add_crlf();
            for (int h = $urandom_range(4); h > 0; h--)
            begin
                case ($urandom_range(3))
                    0:
                    begin
                        add_str("content-length:", 1);
                        repeat ($urandom_range(2)) add_str(" ", 0);
                        if ($urandom_range(9) == 0)
                            add_rand($urandom_range(12, 10), "0", "9");
                        else
                            add_str($sformatf("%0d", $urandom_range(60)), 0);
                        if ($urandom_range(9) == 0) add_rand(2, " ", "~");
                    end
                    1:
                    begin
                        add_str("content-type:", 1);
                        repeat ($urandom_range(2)) add_str(" ", 0);
                        add_rand(($urandom_range(9) == 0) ? 70 : $urandom_range(12), "a", "z");
                        if ($urandom_range(2) == 0) add_str("; charset=x", 0);
                    end
                    2:
                    begin
                        add_str("content-", 1);
                        add_rand($urandom_range(8), " ", "~");
                    end
                    default:
                    begin
                        add_str("x-", 0);
                        add_rand($urandom_range(8), " ", "~");
                        if ($urandom_range(4) == 0) req_q.push_back({1'b0, CH_CR});
                        add_rand($urandom_range(3), " ", "~");
                    end
                endcase
                add_crlf();
            end
            add_crlf();
            add_rand(huge_body ? 200 : $urandom_range(40), 8'h00, 8'hff);
            // cut a few requests short anywhere
            if (kind < 14)
                req_q = req_q[0:$urandom_range(req_q.size() - 1)];
        end
        req_q[$][8] = 1'b1;
    endfunction

    task automatic run_phase(input int target, input int si, input int ri);
        snd_idle = si;
        rcv_idle = ri;
        while (n_items < target)
        begin
            build_request(1'b0);
            foreach (req_q[i]) send(req_q[i][7:0], req_q[i][8]);
        end
        // hold the input until every result has drained
        push <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
    endtask

    // compare each popped transaction with the oldest expectation
    always @(posedge clk)
    begin
        res_t want, got;
        if (rst_n && pop && !empty)
        begin
            got = '{out_byte, segment, status, parsed_length, body_bytes, final_res};
            n_results++;
            if (final_res) n_finals++;
            if (expected_q.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result: got %p", got);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch at result %0d: expected %p, got %p",
                                 n_results, want, got);
                end
            end
        end
        if (rcv_hold > 0)
        begin
            rcv_hold--;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= rcv_idle);
    end

    // end the run if it hangs
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        clear_parse();
        snd_idle = 0;
        rcv_idle = 0;
        rcv_hold = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows; typed rows override the predicted final result
        foreach (dir_tab[i])
        begin
            send(dir_tab[i].b, dir_tab[i].l);
            if (dir_tab[i].typed)
                expected_q[$] = dir_tab[i].r;
        end
        push <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);

        run_phase(450, 27, 83);
        run_phase(850, 83, 27);

        // stall the receiver while a request with a long body is sent, to fill the queue
        rcv_hold = 400;
        snd_idle = 0;
        rcv_idle = 0;
        build_request(1'b1);
        foreach (req_q[i]) send(req_q[i][7:0], req_q[i][8]);
        run_phase(1250, 0, 0);

        repeat (20) @(posedge clk);
        if (expected_q.size() != 0)
            n_mismatch++;
        $display("sent %0d bytes, checked %0d results over %0d requests, %0d mismatches",
                 n_items, n_results, n_finals, n_mismatch);
        if (n_mismatch == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
rtl/hrsp_pkg.sv
rtl/hrsp_front.sv
rtl/hrsp_queue.sv
rtl/http_request_stream_parser_top.sv
tb/sv/tb.sv
